### rtl/cau_pkg.sv
package cau_pkg;

    localparam int FRAC_BITS = 16;
    // Quotient bits that are resolved; anything at or above 2^QB saturates anyway.
    localparam int QB = 33;
    localparam int MAG_W = 64;
    localparam int NUM_W = MAG_W + FRAC_BITS;
    localparam int CMP_W = MAG_W + QB + 1;
    localparam int VAL_W = 66;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic is_div;
        logic dz;
        logic neg_re;
        logic neg_im;
        logic big_re;
        logic big_im;
    } side_t;

    // Applies the sign to a magnitude and saturates; bit 32 is the overflow flag.
    function automatic logic [32:0] finish(input logic neg, input logic big,
                                           input logic [QB-1:0] q);
        logic [32:0] r;
        if (neg) begin
            if (big || q > QB'(33'h080000000))
                r = {1'b1, 32'h80000000};
            else
                r = {1'b0, 32'(~q[31:0] + 32'd1)};
        end
        else begin
            if (big || q > QB'(33'h07FFFFFFF))
                r = {1'b1, 32'h7FFFFFFF};
            else
                r = {1'b0, q[31:0]};
        end
        return r;
    endfunction

endpackage

### rtl/cau_div_pipe.sv
module cau_div_pipe
    import cau_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  side_t            side_in,
    input  logic [MAG_W-1:0] den_in,
    input  logic [NUM_W-1:0] rem_re_in,
    input  logic [NUM_W-1:0] rem_im_in,
    input  logic [QB-1:0]    q_re_in,
    input  logic [QB-1:0]    q_im_in,
    output side_t            side_out,
    output logic [QB-1:0]    q_re_out,
    output logic [QB-1:0]    q_im_out
);

    side_t            side_w [0:QB];
    logic [MAG_W-1:0] den_w  [0:QB];
    logic [NUM_W-1:0] rre_w  [0:QB];
    logic [NUM_W-1:0] rim_w  [0:QB];
    logic [QB-1:0]    qre_w  [0:QB];
    logic [QB-1:0]    qim_w  [0:QB];

    assign side_w[0] = side_in;
    assign den_w[0]  = den_in;
    assign rre_w[0]  = rem_re_in;
    assign rim_w[0]  = rem_im_in;
    assign qre_w[0]  = q_re_in;
    assign qim_w[0]  = q_im_in;

    // One quotient bit per stage, most significant first, for both lanes.
    for (genvar k = 0; k < QB; k++) begin : g_step
        localparam int B = QB - 1 - k;
        side_t            side_reg;
        logic [MAG_W-1:0] den_reg;
        logic [NUM_W-1:0] rre_reg, rre_next, rim_reg, rim_next;
        logic [QB-1:0]    qre_reg, qre_next, qim_reg, qim_next;
        logic [CMP_W-1:0] dsh, xre, xim, dre, dim;

        always_comb
        begin
            dsh = {{(CMP_W-MAG_W){1'b0}}, den_w[k]} << B;
            xre = {{(CMP_W-NUM_W){1'b0}}, rre_w[k]};
            xim = {{(CMP_W-NUM_W){1'b0}}, rim_w[k]};
            dre = xre - dsh;
            dim = xim - dsh;
            rre_next = rre_w[k];
            rim_next = rim_w[k];
            qre_next = qre_w[k];
            qim_next = qim_w[k];
            if (side_w[k].is_div && xre >= dsh) begin
                rre_next = dre[NUM_W-1:0];
                qre_next[B] = 1'b1;
            end
            if (side_w[k].is_div && xim >= dsh) begin
                rim_next = dim[NUM_W-1:0];
                qim_next[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg <= '0;
            else if (en)
                side_reg <= side_w[k];
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                den_reg <= den_w[k];
                rre_reg <= rre_next;
                rim_reg <= rim_next;
                qre_reg <= qre_next;
                qim_reg <= qim_next;
            end
        end

        assign side_w[k+1] = side_reg;
        assign den_w[k+1]  = den_reg;
        assign rre_w[k+1]  = rre_reg;
        assign rim_w[k+1]  = rim_reg;
        assign qre_w[k+1]  = qre_reg;
        assign qim_w[k+1]  = qim_reg;
    end

    assign side_out = side_w[QB];
    assign q_re_out = qre_w[QB];
    assign q_im_out = qim_w[QB];

endmodule

### rtl/complex_arith_unit.sv
// Complex add, subtract, multiply and divide on signed fixed-point operands.
// A request on the input channel (in_valid, in_stall) carries cmd and the two
// operands a and b; every request yields exactly one result request on the
// output channel (out_valid, out_stall) with res_re, res_im, div_zero and
// overflow, in request order.
// The request passes the input register, products, combination, magnitude, a
// range check, 33 divider stages that each resolve one quotient bit, and the
// output register. Add, subtract and multiply ride through the divider stages
// unchanged.
// Throughput is one request per cycle while out_stall does not hold the
// pipeline; the 33-stage restoring divider sets the depth, not the rate.
// When out_stall is high with a result waiting, the whole pipeline holds. One
// further request is caught in an input holding register, and in_stall rises
// on the cycle after that; in_stall is a register output.
// Reset clears every valid bit and the full flag of the holding register; no
// result is shown until a new request has passed through.
module complex_arith_unit
    import cau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] a_re,
    input  logic [31:0] a_im,
    input  logic [31:0] b_re,
    input  logic [31:0] b_im,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] res_re,
    output logic [31:0] res_im,
    output logic        div_zero,
    output logic        overflow
);

    logic en;
    logic acc;

    // Input holding register.
    logic        skid_full_reg, skid_full_next;
    logic [1:0]  skid_cmd_reg;
    logic [31:0] skid_are_reg, skid_aim_reg, skid_bre_reg, skid_bim_reg;

    // Stage 0: operands.
    logic        v0_reg;
    cmd_t        c0_reg;
    logic signed [31:0] are0_reg, aim0_reg, bre0_reg, bim0_reg;

    // Stage 1: products and sums.
    logic        v1_reg;
    cmd_t        c1_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_r_reg, p_bb_i_reg;
    logic signed [32:0] s_re_reg, s_im_reg;

    // Stage 2: exact lane values and |b|^2.
    logic        v2_reg;
    cmd_t        c2_reg;
    logic signed [VAL_W-1:0] val_re_reg, val_re_next, val_im_reg, val_im_next;
    logic [MAG_W-1:0] den2_reg;

    // Stage 3: sign and magnitude.
    side_t            side3_reg, side3_next;
    logic [MAG_W-1:0] den3_reg;
    logic [NUM_W-1:0] rre3_reg, rre3_next, rim3_reg, rim3_next;
    logic [QB-1:0]    qre3_reg, qre3_next, qim3_reg, qim3_next;

    // Stage 4: quotient range check.
    side_t            side4_reg, side4_next;
    logic [MAG_W-1:0] den4_reg;
    logic [NUM_W-1:0] rre4_reg, rim4_reg;
    logic [QB-1:0]    qre4_reg, qim4_reg;

    side_t            side_d;
    logic [QB-1:0]    qre_d, qim_d;

    logic        out_valid_reg;
    logic [31:0] res_re_reg, res_im_reg;
    logic        dz_reg, ovf_reg;
    logic [32:0] fin_re, fin_im;

    assign en  = !(out_valid_reg && out_stall);
    assign acc = in_valid && !skid_full_reg;
    assign in_stall = skid_full_reg;

    always_comb
    begin
        skid_full_next = skid_full_reg;
        if (en)
            skid_full_next = 1'b0;
        else if (acc)
            skid_full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            skid_full_reg <= 1'b0;
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            side3_reg <= '0;
            side4_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            skid_full_reg <= skid_full_next;
            if (en) begin
                v0_reg <= skid_full_reg || acc;
                v1_reg <= v0_reg;
                v2_reg <= v1_reg;
                side3_reg <= side3_next;
                side4_reg <= side4_next;
                out_valid_reg <= side_d.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && acc) begin
            skid_cmd_reg <= cmd;
            skid_are_reg <= a_re;
            skid_aim_reg <= a_im;
            skid_bre_reg <= b_re;
            skid_bim_reg <= b_im;
        end
        if (en) begin
            if (skid_full_reg) begin
                c0_reg   <= cmd_t'(skid_cmd_reg);
                are0_reg <= skid_are_reg;
                aim0_reg <= skid_aim_reg;
                bre0_reg <= skid_bre_reg;
                bim0_reg <= skid_bim_reg;
            end
            else begin
                c0_reg   <= cmd_t'(cmd);
                are0_reg <= a_re;
                aim0_reg <= a_im;
                bre0_reg <= b_re;
                bim0_reg <= b_im;
            end

            c1_reg     <= c0_reg;
            p_rr_reg   <= 64'(are0_reg) * 64'(bre0_reg);
            p_ii_reg   <= 64'(aim0_reg) * 64'(bim0_reg);
            p_ri_reg   <= 64'(are0_reg) * 64'(bim0_reg);
            p_ir_reg   <= 64'(aim0_reg) * 64'(bre0_reg);
            p_bb_r_reg <= 64'(bre0_reg) * 64'(bre0_reg);
            p_bb_i_reg <= 64'(bim0_reg) * 64'(bim0_reg);
            if (c0_reg == CMD_SUB) begin
                s_re_reg <= 33'(are0_reg) - 33'(bre0_reg);
                s_im_reg <= 33'(aim0_reg) - 33'(bim0_reg);
            end
            else begin
                s_re_reg <= 33'(are0_reg) + 33'(bre0_reg);
                s_im_reg <= 33'(aim0_reg) + 33'(bim0_reg);
            end

            c2_reg     <= c1_reg;
            val_re_reg <= val_re_next;
            val_im_reg <= val_im_next;
            den2_reg   <= MAG_W'(p_bb_r_reg) + MAG_W'(p_bb_i_reg);

            den3_reg <= den2_reg;
            rre3_reg <= rre3_next;
            rim3_reg <= rim3_next;
            qre3_reg <= qre3_next;
            qim3_reg <= qim3_next;

            den4_reg <= den3_reg;
            rre4_reg <= rre3_reg;
            rim4_reg <= rim3_reg;
            qre4_reg <= qre3_reg;
            qim4_reg <= qim3_reg;

            if (side_d.dz) begin
                res_re_reg <= '0;
                res_im_reg <= '0;
                ovf_reg    <= 1'b0;
            end
            else begin
                res_re_reg <= fin_re[31:0];
                res_im_reg <= fin_im[31:0];
                ovf_reg    <= fin_re[32] || fin_im[32];
            end
            dz_reg <= side_d.dz;
        end
    end

    always_comb
    begin
        case (c1_reg)
            CMD_ADD, CMD_SUB:
            begin
                val_re_next = VAL_W'(s_re_reg);
                val_im_next = VAL_W'(s_im_reg);
            end
            CMD_MUL:
            begin
                val_re_next = VAL_W'(p_rr_reg) - VAL_W'(p_ii_reg);
                val_im_next = VAL_W'(p_ri_reg) + VAL_W'(p_ir_reg);
            end
            default:
            begin
                val_re_next = VAL_W'(p_rr_reg) + VAL_W'(p_ii_reg);
                val_im_next = VAL_W'(p_ir_reg) - VAL_W'(p_ri_reg);
            end
        endcase
    end

    // Magnitudes never exceed 2^63, so 64 bits hold them.
    logic [VAL_W-1:0] neg_re_w, neg_im_w;
    logic [MAG_W-1:0] mag_re, mag_im, sh_re, sh_im;
    logic             is_div2;

    always_comb
    begin
        is_div2  = (c2_reg == CMD_DIV);
        neg_re_w = VAL_W'(-val_re_reg);
        neg_im_w = VAL_W'(-val_im_reg);
        mag_re = val_re_reg[VAL_W-1] ? neg_re_w[MAG_W-1:0] : val_re_reg[MAG_W-1:0];
        mag_im = val_im_reg[VAL_W-1] ? neg_im_w[MAG_W-1:0] : val_im_reg[MAG_W-1:0];
        sh_re = (c2_reg == CMD_MUL) ? (mag_re >> FRAC_BITS) : mag_re;
        sh_im = (c2_reg == CMD_MUL) ? (mag_im >> FRAC_BITS) : mag_im;

        side3_next.valid  = v2_reg;
        side3_next.is_div = is_div2;
        side3_next.dz     = is_div2 && (den2_reg == '0);
        side3_next.neg_re = val_re_reg[VAL_W-1];
        side3_next.neg_im = val_im_reg[VAL_W-1];
        side3_next.big_re = !is_div2 && (|sh_re[MAG_W-1:QB]);
        side3_next.big_im = !is_div2 && (|sh_im[MAG_W-1:QB]);

        if (is_div2) begin
            rre3_next = {mag_re, {FRAC_BITS{1'b0}}};
            rim3_next = {mag_im, {FRAC_BITS{1'b0}}};
            qre3_next = '0;
            qim3_next = '0;
        end
        else begin
            rre3_next = '0;
            rim3_next = '0;
            qre3_next = sh_re[QB-1:0];
            qim3_next = sh_im[QB-1:0];
        end
    end

    // A quotient of 2^QB or more saturates whatever its low bits are.
    logic [CMP_W-1:0] dtop, nre, nim;

    always_comb
    begin
        dtop = {1'b0, den3_reg, {QB{1'b0}}};
        nre  = {{(CMP_W-NUM_W){1'b0}}, rre3_reg};
        nim  = {{(CMP_W-NUM_W){1'b0}}, rim3_reg};
        side4_next = side3_reg;
        if (side3_reg.is_div) begin
            side4_next.big_re = (nre >= dtop);
            side4_next.big_im = (nim >= dtop);
        end
    end

    cau_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .side_in   (side4_reg),
        .den_in    (den4_reg),
        .rem_re_in (rre4_reg),
        .rem_im_in (rim4_reg),
        .q_re_in   (qre4_reg),
        .q_im_in   (qim4_reg),
        .side_out  (side_d),
        .q_re_out  (qre_d),
        .q_im_out  (qim_d)
    );

    assign fin_re = finish(side_d.neg_re, side_d.big_re, qre_d);
    assign fin_im = finish(side_d.neg_im, side_d.big_im, qim_d);

    assign out_valid = out_valid_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign div_zero  = dz_reg;
    assign overflow  = ovf_reg;

endmodule
